// ===== rtl/smsrng_pkg.sv =====
// ----------------------------------------------------------------------------
// smsrng_pkg: constants of the shuffled minimal standard generator
// Generator constants, shuffle table geometry and the widths derived from them.
// ----------------------------------------------------------------------------
package smsrng_pkg;

	localparam int TABLE_DEPTH  = 32;
	localparam int WARMUP_STEPS = 8;
	localparam int INIT_STEPS   = TABLE_DEPTH + WARMUP_STEPS;

	localparam int VAL_W  = 31;
	localparam int MULT_W = 15;
	localparam int PROD_W = VAL_W + MULT_W;
	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(INIT_STEPS);

	// The table depth is a power of two, so the selector divisor
	// 1 + (2^31 - 2) / TABLE_DEPTH is 2^(31 - IDX_W) and the index is the top bits.
	localparam int SEL_LSB = VAL_W - IDX_W;

	localparam logic [MULT_W-1:0] LEHMER_MULT = MULT_W'(16807);
	localparam logic [VAL_W-1:0]  LEHMER_MOD  = {VAL_W{1'b1}};

	typedef logic [VAL_W-1:0] value_t;

endpackage

// ===== rtl/shuffled_minimal_standard_rng.sv =====
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_rng: Lehmer generator with a Bays-Durham shuffle
// A 16807 * x mod (2^31 - 1) generator feeds a 32-entry shuffle table; each
// input transfer draws one shuffled 31-bit deviate.
//
// Channel   Signals                             Payload
// input     in_valid, in_ready                  restart
// output    out_valid, out_ready                deviate
// config    cfg_wr_en                           cfg_wr_data (seed)
//
// One generator step is a multiply state and a reduction state through the
// single shared multiplier and Mersenne-modulus adder.
// A draw runs through the multiply, reduction and final states and takes no
// new item before it returns to idle; a restart first runs the
// TABLE_DEPTH + WARMUP_STEPS steps of the seed reload and table fill.
// The first draw after reset always performs the reload.
// A new item is taken while a result still waits; the draw stalls in its last
// cycle until the output register is free.
// ----------------------------------------------------------------------------
module shuffled_minimal_standard_rng
	import smsrng_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [VAL_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             restart,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [VAL_W-1:0] deviate
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_RED  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(INIT_STEPS - 1);
	localparam logic [CNT_W-1:0] CNT_WARMUP = CNT_W'(WARMUP_STEPS);

	logic [1:0]        state_q;
	logic              init_q;
	logic [CNT_W-1:0]  cnt_q;
	value_t            seed_q;
	value_t            x_q;
	value_t            last_q;
	logic [PROD_W-1:0] prod_q;
	value_t            rd_q;
	value_t            deviate_q;
	logic              ov_q;
	value_t            table_mem [TABLE_DEPTH];

	logic              in_xfer;
	logic              out_free;
	value_t            seed_fix;
	logic [VAL_W:0]    red_sum;
	value_t            red_val;
	logic [IDX_W-1:0]  sel_idx;
	logic [IDX_W-1:0]  fill_idx;
	logic              fill_we;
	logic              draw_we;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign deviate   = deviate_q;

	assign seed_fix = (seed_q == '0 || seed_q == LEHMER_MOD) ? VAL_W'(1) : seed_q;

	assign red_sum = {1'b0, prod_q[VAL_W-1:0]} + (VAL_W+1)'(prod_q[PROD_W-1:VAL_W]);
	assign red_val = (red_sum >= {1'b0, LEHMER_MOD}) ?
		VAL_W'(red_sum - {1'b0, LEHMER_MOD}) : red_sum[VAL_W-1:0];

	assign sel_idx  = last_q[VAL_W-1:SEL_LSB];
	assign fill_idx = IDX_W'(CNT_LAST - cnt_q);
	assign fill_we  = (state_q == ST_RED) && init_q && (cnt_q >= CNT_WARMUP);
	assign draw_we  = (state_q == ST_RED) && !init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= VAL_W'(1);
		end else if (cfg_wr_en) begin
			seed_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			init_q    <= 1'b0;
			cnt_q     <= '0;
			x_q       <= VAL_W'(1);
			last_q    <= '0;
			ov_q      <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_MUL;
						if (restart || last_q == '0) begin
							init_q <= 1'b1;
							cnt_q  <= '0;
							x_q    <= seed_fix;
						end else begin
							init_q <= 1'b0;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_RED;
				end
				ST_RED: begin
					x_q <= red_val;
					if (init_q) begin
						state_q <= ST_MUL;
						if (cnt_q == CNT_LAST) begin
							init_q <= 1'b0;
							last_q <= red_val;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						last_q  <= rd_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(x_q) * PROD_W'(LEHMER_MULT);
		end
		if (state_q == ST_FIN && out_free) begin
			deviate_q <= rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			table_mem[fill_idx] <= red_val;
		end
		if (draw_we) begin
			table_mem[sel_idx] <= red_val;
			rd_q               <= table_mem[sel_idx];
		end
	end

	a_gen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		x_q != '0)
		else $error("Generator state reached zero.");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("Input taken again right after a transfer.");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q) == ST_FIN)
		else $error("Output became valid outside the final draw cycle.");

	a_draw_initialized: assert property (@(posedge clk) disable iff (!arst_n)
		draw_we |-> last_q != '0)
		else $error("Draw started from an uninitialized table.");

	a_deviate_range: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (deviate_q != '0 && deviate_q != LEHMER_MOD))
		else $error("Deviate outside its range.");

endmodule
